FILE: design/dspd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dspd_pkg;

	// Field and datapath widths
	localparam int POS_W      = 24;
	localparam int ANGLE_W    = 14;
	localparam int YAW_W      = 13;
	localparam int HEAD_W     = 13;
	localparam int DRIVE_W    = 24;
	localparam int GAIN_W     = 16;
	localparam int TIMEOUT_W  = 8;
	localparam int LAT_ERR_W  = POS_W + 1;
	localparam int TURN_ERR_W = 16;
	localparam int INTEG_W    = 48;
	localparam int HALF_W     = INTEG_W / 2;
	localparam int SUM_W      = INTEG_W + GAIN_W + 2;
	localparam int FRAC_SHIFT = 4;
	localparam int PID_W      = SUM_W - FRAC_SHIFT;
	localparam int CNT_W      = 16;
	localparam int BAND_CNT_W = 4;

	// Move supervision constants
	localparam int BAND_LIMIT       = 32;
	localparam int SETTLE_COUNT     = 10;
	localparam int TICKS_PER_SECOND = 50;

	// Register map
	typedef enum logic [2:0] {
		CFG_KP,
		CFG_KI,
		CFG_KD,
		CFG_TURN_KP,
		CFG_TURN_KI,
		CFG_TURN_KD,
		CFG_MAX_POWER,
		CFG_TIMEOUT
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_RUNNING   = 2'd0,
		ST_SETTLED   = 2'd1,
		ST_TIMED_OUT = 2'd2
	} status_t;

	// Stage load strobes for one PID lane
	typedef struct packed {
		logic load_s3;
		logic load_s4;
	} lane_ctl_t;

endpackage

`default_nettype wire

FILE: design/dspd_pid_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module dspd_pid_lane import dspd_pkg::*; #(
	parameter int ERR_W = LAT_ERR_W
) (
	input  logic                     clk,
	input  lane_ctl_t                ctl,
	input  logic signed [ERR_W-1:0]  err,
	input  logic signed [INTEG_W-1:0] integ,
	input  logic signed [ERR_W:0]    deriv,
	input  logic [GAIN_W-1:0]        gain_p,
	input  logic [GAIN_W-1:0]        gain_i,
	input  logic [GAIN_W-1:0]        gain_d,
	output logic signed [PID_W-1:0]  term_s4
);

	localparam int HI_PAD = SUM_W - 2 * HALF_W - GAIN_W - 1;
	localparam int LO_PAD = SUM_W - HALF_W - GAIN_W;

	logic signed [ERR_W+GAIN_W:0]    prop_s3;
	logic signed [ERR_W+GAIN_W+1:0]  der_s3;
	logic [HALF_W+GAIN_W-1:0]        ilo_s3;
	logic signed [HALF_W+GAIN_W:0]   ihi_s3;
	logic [SUM_W-1:0]                prop_ext;
	logic [SUM_W-1:0]                der_ext;
	logic [SUM_W-1:0]                ilo_ext;
	logic [SUM_W-1:0]                ihi_ext;
	logic [SUM_W-1:0]                sum;

	// Form partial products; the integral is split in two halves
	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			prop_s3 <= err * $signed({1'b0, gain_p});
			der_s3  <= deriv * $signed({1'b0, gain_d});
			ilo_s3  <= integ[HALF_W-1:0] * gain_i;
			ihi_s3  <= $signed(integ[INTEG_W-1:HALF_W]) * $signed({1'b0, gain_i});
		end
	end

	// Align each partial product to the full sum width; the low integral half is zero-extended, the rest sign-extended
	assign prop_ext = {{(SUM_W-ERR_W-GAIN_W-1){prop_s3[ERR_W+GAIN_W]}}, prop_s3};
	assign der_ext  = {{(SUM_W-ERR_W-GAIN_W-2){der_s3[ERR_W+GAIN_W+1]}}, der_s3};
	assign ilo_ext  = {{LO_PAD{1'b0}}, ilo_s3};
	assign ihi_ext  = {{HI_PAD{ihi_s3[HALF_W+GAIN_W]}}, ihi_s3, {HALF_W{1'b0}}};
	assign sum      = prop_ext + der_ext + ilo_ext + ihi_ext;

	// Drop the fraction bits, rounding toward minus infinity
	always_ff @(posedge clk) begin
		if (ctl.load_s4) begin
			term_s4 <= $signed(sum[SUM_W-1:FRAC_SHIFT]);
		end
	end

endmodule

`default_nettype wire

FILE: design/dual_side_pid_drive_with_heading.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid / in_stall    start_req, targets, positions, yaw, heading, use_heading
// out       out_valid / out_stall  left_drive, right_drive, status
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per clock while the output is not stalled; a request passes the stage
// registers and then the output register. The rate is set by the stage-2 update of the
// integrals, last errors and tick counters, which each request reads and rewrites in stage 2.
// Reset clears the pipeline, the loop state and loads the default gains and limits.
// A stalled output holds; the stages behind it keep filling until all are full.

module dual_side_pid_drive_with_heading import dspd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      start_req,
	input  logic signed [POS_W-1:0]   target_distance,
	input  logic signed [ANGLE_W-1:0] target_angle,
	input  logic signed [POS_W-1:0]   left_position,
	input  logic signed [POS_W-1:0]   right_raw_position,
	input  logic signed [YAW_W-1:0]   yaw_angle,
	input  logic [HEAD_W-1:0]         heading_angle,
	input  logic                      use_heading,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DRIVE_W-1:0] left_drive,
	output logic signed [DRIVE_W-1:0] right_drive,
	output logic [1:0]                status,
	// configuration channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data
);

	localparam logic signed [LAT_ERR_W-1:0] BAND_HI = LAT_ERR_W'(BAND_LIMIT);
	localparam logic signed [LAT_ERR_W-1:0] BAND_LO = -BAND_HI;

	// configuration registers
	logic [GAIN_W-1:0]    kp_q, ki_q, kd_q;
	logic [GAIN_W-1:0]    turn_kp_q, turn_ki_q, turn_kd_q;
	logic [GAIN_W-1:0]    max_power_q;
	logic [TIMEOUT_W-1:0] timeout_q;

	// loop state
	logic signed [INTEG_W-1:0]    left_integ_q, right_integ_q, turn_integ_q;
	logic signed [LAT_ERR_W-1:0]  left_last_q, right_last_q;
	logic signed [TURN_ERR_W-1:0] turn_last_q;
	logic [BAND_CNT_W-1:0]        band_cnt_q;
	logic [CNT_W-1:0]             elapsed_q;

	// pipeline handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic rdy_1, rdy_2, rdy_3, rdy_4, rdy_out;
	logic adv_2;

	// stage 1 payload
	logic                      start_s1;
	logic signed [POS_W-1:0]   tgt_s1, lpos_s1, rraw_s1;
	logic signed [ANGLE_W-1:0] tang_s1;
	logic signed [YAW_W-1:0]   yaw_s1;
	logic [HEAD_W-1:0]         head_s1;
	logic                      use_head_s1;

	// stage 2 logic and payload
	logic signed [LAT_ERR_W-1:0]  left_err, right_err;
	logic signed [TURN_ERR_W-1:0] turn_src, turn_err;
	logic signed [INTEG_W-1:0]    left_integ_nx, right_integ_nx, turn_integ_nx;
	logic signed [LAT_ERR_W:0]    left_der, right_der;
	logic signed [TURN_ERR_W:0]   turn_der;
	logic [BAND_CNT_W-1:0]        band_cur, band_nx;
	logic [CNT_W-1:0]             elapsed_cur, elapsed_nx, timeout_limit;
	logic                         in_band;
	status_t                      status_nx;

	logic signed [LAT_ERR_W-1:0]  left_err_s2, right_err_s2;
	logic signed [TURN_ERR_W-1:0] turn_err_s2;
	logic signed [INTEG_W-1:0]    left_integ_s2, right_integ_s2, turn_integ_s2;
	logic signed [LAT_ERR_W:0]    left_der_s2, right_der_s2;
	logic signed [TURN_ERR_W:0]   turn_der_s2;
	status_t                      status_s2, status_s3, status_s4;

	// lane results and output stage
	lane_ctl_t                 lane_ctl;
	logic signed [PID_W-1:0]   left_term_s4, right_term_s4, turn_term_s4;
	logic signed [PID_W-1:0]   max_power_ext, left_lim, right_lim;
	logic signed [PID_W:0]     left_sum, right_sum;
	logic signed [DRIVE_W-1:0] left_drive_q, right_drive_q;
	status_t                   status_q;

	function automatic logic signed [INTEG_W-1:0] sat_integ(
		input logic signed [INTEG_W-1:0]   acc,
		input logic signed [LAT_ERR_W-1:0] e
	);
		logic [INTEG_W:0] s;
		s = {acc[INTEG_W-1], acc} + {{(INTEG_W+1-LAT_ERR_W){e[LAT_ERR_W-1]}}, e};
		if (s[INTEG_W] != s[INTEG_W-1]) begin
			sat_integ = s[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			sat_integ = $signed(s[INTEG_W-1:0]);
		end
	endfunction

	function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [PID_W:0] x);
		if (&x[PID_W:DRIVE_W-1] || ~|x[PID_W:DRIVE_W-1]) begin
			sat_drive = x[DRIVE_W-1:0];
		end else begin
			sat_drive = x[PID_W] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
		end
	endfunction

	// Write configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= GAIN_W'(179);
			ki_q        <= '0;
			kd_q        <= GAIN_W'(512);
			turn_kp_q   <= GAIN_W'(51);
			turn_ki_q   <= '0;
			turn_kd_q   <= '0;
			max_power_q <= GAIN_W'(2560);
			timeout_q   <= TIMEOUT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KP:        kp_q        <= cfg_data;
				CFG_KI:        ki_q        <= cfg_data;
				CFG_KD:        kd_q        <= cfg_data;
				CFG_TURN_KP:   turn_kp_q   <= cfg_data;
				CFG_TURN_KI:   turn_ki_q   <= cfg_data;
				CFG_TURN_KD:   turn_kd_q   <= cfg_data;
				CFG_MAX_POWER: max_power_q <= cfg_data;
				CFG_TIMEOUT:   timeout_q   <= cfg_data[TIMEOUT_W-1:0];
			endcase
		end
	end

	// Advance each stage when it is empty or the one after it moves
	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_4    = !valid_s4 || rdy_out;
	assign rdy_3    = !valid_s3 || rdy_4;
	assign rdy_2    = !valid_s2 || rdy_3;
	assign rdy_1    = !valid_s1 || rdy_2;
	assign in_stall = !rdy_1;
	assign adv_2    = rdy_2 && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_1)   valid_s1    <= in_valid;
			if (rdy_2)   valid_s2    <= valid_s1;
			if (rdy_3)   valid_s3    <= valid_s2;
			if (rdy_4)   valid_s4    <= valid_s3;
			if (rdy_out) out_valid_q <= valid_s4;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (rdy_1 && in_valid) begin
			start_s1    <= start_req;
			tgt_s1      <= target_distance;
			tang_s1     <= target_angle;
			lpos_s1     <= left_position;
			rraw_s1     <= right_raw_position;
			yaw_s1      <= yaw_angle;
			head_s1     <= heading_angle;
			use_head_s1 <= use_heading;
		end
	end

	// Form errors, derivatives and saturated integrals
	always_comb begin
		left_err  = {tgt_s1[POS_W-1], tgt_s1} - {lpos_s1[POS_W-1], lpos_s1};
		right_err = {tgt_s1[POS_W-1], tgt_s1} + {rraw_s1[POS_W-1], rraw_s1};
		turn_src  = use_head_s1 ? $signed({{(TURN_ERR_W-HEAD_W){1'b0}}, head_s1})
		                        : $signed({{(TURN_ERR_W-YAW_W){yaw_s1[YAW_W-1]}}, yaw_s1});
		turn_err  = turn_src - {{(TURN_ERR_W-ANGLE_W){tang_s1[ANGLE_W-1]}}, tang_s1};

		left_integ_nx  = sat_integ(left_integ_q, left_err);
		right_integ_nx = sat_integ(right_integ_q, right_err);
		turn_integ_nx  = sat_integ(turn_integ_q,
			{{(LAT_ERR_W-TURN_ERR_W){turn_err[TURN_ERR_W-1]}}, turn_err});

		left_der  = {left_err[LAT_ERR_W-1], left_err} - {left_last_q[LAT_ERR_W-1], left_last_q};
		right_der = {right_err[LAT_ERR_W-1], right_err}
		          - {right_last_q[LAT_ERR_W-1], right_last_q};
		turn_der  = {turn_err[TURN_ERR_W-1], turn_err} - {turn_last_q[TURN_ERR_W-1], turn_last_q};
	end

	// Settle and timeout supervision; a start request restarts both counters
	always_comb begin
		band_cur      = start_s1 ? '0 : band_cnt_q;
		elapsed_cur   = start_s1 ? '0 : elapsed_q;
		timeout_limit = (CNT_W'(timeout_q) + CNT_W'(1)) * CNT_W'(TICKS_PER_SECOND);
		in_band       = (left_err >= BAND_LO) && (left_err <= BAND_HI)
		             && (right_err >= BAND_LO) && (right_err <= BAND_HI);
		status_nx     = ST_RUNNING;
		band_nx       = '0;
		if (in_band) begin
			if (band_cur >= BAND_CNT_W'(SETTLE_COUNT)) begin
				status_nx = ST_SETTLED;
				band_nx   = band_cur;
			end else begin
				band_nx = band_cur + BAND_CNT_W'(1);
			end
		end
		if (status_nx == ST_RUNNING && elapsed_cur >= timeout_limit) begin
			status_nx = ST_TIMED_OUT;
		end
		elapsed_nx = (&elapsed_cur) ? elapsed_cur : elapsed_cur + CNT_W'(1);
	end

	// Update loop state as each request passes stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_integ_q  <= '0;
			right_integ_q <= '0;
			turn_integ_q  <= '0;
			left_last_q   <= '0;
			right_last_q  <= '0;
			turn_last_q   <= '0;
			band_cnt_q    <= '0;
			elapsed_q     <= '0;
		end else if (adv_2) begin
			left_integ_q  <= left_integ_nx;
			right_integ_q <= right_integ_nx;
			turn_integ_q  <= turn_integ_nx;
			left_last_q   <= left_err;
			right_last_q  <= right_err;
			turn_last_q   <= turn_err;
			band_cnt_q    <= band_nx;
			elapsed_q     <= elapsed_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_2) begin
			left_err_s2    <= left_err;
			right_err_s2   <= right_err;
			turn_err_s2    <= turn_err;
			left_integ_s2  <= left_integ_nx;
			right_integ_s2 <= right_integ_nx;
			turn_integ_s2  <= turn_integ_nx;
			left_der_s2    <= left_der;
			right_der_s2   <= right_der;
			turn_der_s2    <= turn_der;
			status_s2      <= status_nx;
		end
	end

	// Carry status alongside the lanes
	assign lane_ctl.load_s3 = rdy_3 && valid_s2;
	assign lane_ctl.load_s4 = rdy_4 && valid_s3;

	always_ff @(posedge clk) begin
		if (lane_ctl.load_s3) status_s3 <= status_s2;
		if (lane_ctl.load_s4) status_s4 <= status_s3;
	end

	dspd_pid_lane #(.ERR_W(LAT_ERR_W)) u_left_lane (
		.clk     (clk),
		.ctl     (lane_ctl),
		.err     (left_err_s2),
		.integ   (left_integ_s2),
		.deriv   (left_der_s2),
		.gain_p  (kp_q),
		.gain_i  (ki_q),
		.gain_d  (kd_q),
		.term_s4 (left_term_s4)
	);

	dspd_pid_lane #(.ERR_W(LAT_ERR_W)) u_right_lane (
		.clk     (clk),
		.ctl     (lane_ctl),
		.err     (right_err_s2),
		.integ   (right_integ_s2),
		.deriv   (right_der_s2),
		.gain_p  (kp_q),
		.gain_i  (ki_q),
		.gain_d  (kd_q),
		.term_s4 (right_term_s4)
	);

	dspd_pid_lane #(.ERR_W(TURN_ERR_W)) u_turn_lane (
		.clk     (clk),
		.ctl     (lane_ctl),
		.err     (turn_err_s2),
		.integ   (turn_integ_s2),
		.deriv   (turn_der_s2),
		.gain_p  (turn_kp_q),
		.gain_i  (turn_ki_q),
		.gain_d  (turn_kd_q),
		.term_s4 (turn_term_s4)
	);

	// Clamp lateral power from above, then mix in heading power
	always_comb begin
		max_power_ext = $signed({{(PID_W-GAIN_W){1'b0}}, max_power_q});
		left_lim      = (left_term_s4 > max_power_ext) ? max_power_ext : left_term_s4;
		right_lim     = (right_term_s4 > max_power_ext) ? max_power_ext : right_term_s4;
		left_sum      = {left_lim[PID_W-1], left_lim} - {turn_term_s4[PID_W-1], turn_term_s4};
		right_sum     = {right_lim[PID_W-1], right_lim} + {turn_term_s4[PID_W-1], turn_term_s4};
	end

	always_ff @(posedge clk) begin
		if (rdy_out && valid_s4) begin
			left_drive_q  <= sat_drive(left_sum);
			right_drive_q <= sat_drive(right_sum);
			status_q      <= status_s4;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_drive  = left_drive_q;
	assign right_drive = right_drive_q;
	assign status      = status_q;

	// Checks
	a_no_stall_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while the output side is free");

	a_band_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		band_cnt_q <= BAND_CNT_W'(SETTLE_COUNT))
		else $error("in-band tick count ran past the settle count");

	a_elapsed_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv_2 |=> elapsed_q != '0)
		else $error("elapsed ticks not advanced by a request");

	a_settled_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_2 && status_nx == ST_SETTLED)
			|-> (!start_s1 && band_cnt_q == BAND_CNT_W'(SETTLE_COUNT)))
		else $error("settled reported without a full in-band run");

endmodule

`default_nettype wire

FILE: tb/drive_cmd_checker.sv
`timescale 1ns / 1ps

module drive_cmd_checker import dspd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      start_req,
	input  logic signed [POS_W-1:0]   target_distance,
	input  logic signed [ANGLE_W-1:0] target_angle,
	input  logic signed [POS_W-1:0]   left_position,
	input  logic signed [POS_W-1:0]   right_raw_position,
	input  logic signed [YAW_W-1:0]   yaw_angle,
	input  logic [HEAD_W-1:0]         heading_angle,
	input  logic                      use_heading,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [DRIVE_W-1:0] left_drive,
	input  logic signed [DRIVE_W-1:0] right_drive,
	input  logic [1:0]                status,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data,
	output int                        err_count,
	output int                        outstanding,
	output int                        checked,
	output int                        settled_seen,
	output int                        timeout_seen
);

	// Wide enough for the exact PID sum before the shift
	typedef logic signed [SUM_W-1:0] wide_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] left;
		logic signed [DRIVE_W-1:0] right;
		status_t                   st;
	} drive_cmd_t;

	localparam wide_t INTEG_HI = (wide_t'(1) <<< (INTEG_W - 1)) - 1;
	localparam wide_t INTEG_LO = -(wide_t'(1) <<< (INTEG_W - 1));
	localparam wide_t DRV_HI   = (wide_t'(1) <<< (DRIVE_W - 1)) - 1;
	localparam wide_t DRV_LO   = -(wide_t'(1) <<< (DRIVE_W - 1));

	// Local copy of the register file
	logic [GAIN_W-1:0]    g_kp, g_ki, g_kd, g_tkp, g_tki, g_tkd, g_maxp;
	logic [TIMEOUT_W-1:0] g_timeout;

	// Loop state mirrored from the block
	wide_t lft_integ, rgt_integ, hdg_integ;
	wide_t lft_prev, rgt_prev, hdg_prev;
	int    band_run;
	int    tick_age;

	drive_cmd_t pending_cmds[$];

	function automatic wide_t clamp_wide(wide_t x, wide_t lo, wide_t hi);
		if (x < lo) return lo;
		if (x > hi) return hi;
		return x;
	endfunction

	// Exact P + I + D sum, floored from 1/4096 V down to 1/256 V
	function automatic wide_t pid_power(wide_t err, wide_t acc, wide_t delta,
		logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi, logic [GAIN_W-1:0] gd);
		wide_t wp, wi, wd;
		wp = gp;
		wi = gi;
		wd = gd;
		return (err * wp + acc * wi + delta * wd) >>> FRAC_SHIFT;
	endfunction

	// Advance the loop state by one control tick and return the drive command
	function automatic drive_cmd_t predict_drive_cmd(
		logic                      start,
		logic signed [POS_W-1:0]   tgt_in,
		logic signed [ANGLE_W-1:0] tang_in,
		logic signed [POS_W-1:0]   lpos_in,
		logic signed [POS_W-1:0]   rraw_in,
		logic signed [YAW_W-1:0]   yaw_in,
		logic [HEAD_W-1:0]         head_in,
		logic                      use_h);
		wide_t tgt, tang, yaw, head, maxp;
		wide_t le, re, te, lp, rp, tp;
		drive_cmd_t cmd;
		if (start) begin
			band_run = 0;
			tick_age = 0;
		end
		tgt  = tgt_in;
		tang = tang_in;
		yaw  = yaw_in;
		head = head_in;
		le = tgt - lpos_in;
		re = tgt + rraw_in;
		if (use_h) begin
			te = head - tang;
		end else begin
			te = yaw - tang;
		end

		lft_integ = clamp_wide(lft_integ + le, INTEG_LO, INTEG_HI);
		rgt_integ = clamp_wide(rgt_integ + re, INTEG_LO, INTEG_HI);
		hdg_integ = clamp_wide(hdg_integ + te, INTEG_LO, INTEG_HI);

		lp = pid_power(le, lft_integ, le - lft_prev, g_kp, g_ki, g_kd);
		rp = pid_power(re, rgt_integ, re - rgt_prev, g_kp, g_ki, g_kd);
		tp = pid_power(te, hdg_integ, te - hdg_prev, g_tkp, g_tki, g_tkd);

		// Clamp lateral power from above only, then mix in heading
		maxp = g_maxp;
		if (lp > maxp) lp = maxp;
		if (rp > maxp) rp = maxp;
		cmd.left  = DRIVE_W'(clamp_wide(lp - tp, DRV_LO, DRV_HI));
		cmd.right = DRIVE_W'(clamp_wide(rp + tp, DRV_LO, DRV_HI));

		lft_prev = le;
		rgt_prev = re;
		hdg_prev = te;

		// Settle run, then timeout on whole seconds
		cmd.st = ST_RUNNING;
		if (le >= -BAND_LIMIT && le <= BAND_LIMIT && re >= -BAND_LIMIT && re <= BAND_LIMIT) begin
			if (band_run >= SETTLE_COUNT) begin
				cmd.st = ST_SETTLED;
			end else begin
				band_run++;
			end
		end else begin
			band_run = 0;
		end
		if (cmd.st == ST_RUNNING && tick_age / TICKS_PER_SECOND > g_timeout) begin
			cmd.st = ST_TIMED_OUT;
		end
		if (tick_age < 65535) tick_age++;
		return cmd;
	endfunction

	task automatic report_mismatch(input string what, input longint got_v, input longint exp_v);
		$display("MISMATCH %s: got %0d, want %0d at %0t", what, got_v, exp_v, $time);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		drive_cmd_t want;
		if (!arst_n) begin
			g_kp      = 16'd179;
			g_ki      = 16'd0;
			g_kd      = 16'd512;
			g_tkp     = 16'd51;
			g_tki     = 16'd0;
			g_tkd     = 16'd0;
			g_maxp    = 16'd2560;
			g_timeout = 8'd1;
			lft_integ = '0;
			rgt_integ = '0;
			hdg_integ = '0;
			lft_prev  = '0;
			rgt_prev  = '0;
			hdg_prev  = '0;
			band_run  = 0;
			tick_age  = 0;
			pending_cmds.delete();
			outstanding = 0;
		end else begin
			// Track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_KP:        g_kp      = cfg_data;
					CFG_KI:        g_ki      = cfg_data;
					CFG_KD:        g_kd      = cfg_data;
					CFG_TURN_KP:   g_tkp     = cfg_data;
					CFG_TURN_KI:   g_tki     = cfg_data;
					CFG_TURN_KD:   g_tkd     = cfg_data;
					CFG_MAX_POWER: g_maxp    = cfg_data;
					CFG_TIMEOUT:   g_timeout = cfg_data[TIMEOUT_W-1:0];
					default: ;
				endcase
			end

			// Compare each taken result with the oldest prediction
			if (out_valid && !out_stall) begin
				if (pending_cmds.size() == 0) begin
					report_mismatch("result with no request pending", left_drive, 0);
				end else begin
					want = pending_cmds.pop_front();
					checked++;
					if (left_drive !== want.left)
						report_mismatch("left_drive", left_drive, want.left);
					if (right_drive !== want.right)
						report_mismatch("right_drive", right_drive, want.right);
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (want.st == ST_SETTLED) settled_seen++;
					if (want.st == ST_TIMED_OUT) timeout_seen++;
				end
			end

			// Predict each taken request
			if (in_valid && !in_stall) begin
				pending_cmds.push_back(predict_drive_cmd(start_req, target_distance,
					target_angle, left_position, right_raw_position, yaw_angle,
					heading_angle, use_heading));
			end
			outstanding = pending_cmds.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dspd_pkg::*;

	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int LONG_HOLD       = 300;
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct {
		logic                      start;
		logic signed [POS_W-1:0]   tgt;
		logic signed [ANGLE_W-1:0] tang;
		logic signed [POS_W-1:0]   lpos;
		logic signed [POS_W-1:0]   rraw;
		logic signed [YAW_W-1:0]   yaw;
		logic [HEAD_W-1:0]         head;
		logic                      use_h;
	} tick_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      start_req;
	logic signed [POS_W-1:0]   target_distance;
	logic signed [ANGLE_W-1:0] target_angle;
	logic signed [POS_W-1:0]   left_position;
	logic signed [POS_W-1:0]   right_raw_position;
	logic signed [YAW_W-1:0]   yaw_angle;
	logic [HEAD_W-1:0]         heading_angle;
	logic                      use_heading;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [DRIVE_W-1:0] left_drive;
	logic signed [DRIVE_W-1:0] right_drive;
	logic [1:0]                status;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [2:0]                cfg_index;
	logic [GAIN_W-1:0]         cfg_data;

	int err_count;
	int outstanding;
	int checked;
	int settled_seen;
	int timeout_seen;

	int sent_ticks   = 0;
	int in_idle_pct  = 17;
	int stall_pct    = 17;
	int hold_trigger = 0;
	int cycles       = 0;

	dual_side_pid_drive_with_heading u_dut (.*);

	drive_cmd_checker u_drive_check (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Output back-pressure: random stalls, plus a long hold on request
	initial begin : stall_gen
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	function automatic int clip_int(int x, int lo, int hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	function automatic tick_t make_tick(logic st, int tgt, int tang, int lpos, int rraw,
		int yaw, int head, logic uh);
		tick_t t;
		t.start = st;
		t.tgt   = POS_W'(tgt);
		t.tang  = ANGLE_W'(tang);
		t.lpos  = POS_W'(lpos);
		t.rraw  = POS_W'(rraw);
		t.yaw   = YAW_W'(yaw);
		t.head  = HEAD_W'(head);
		t.use_h = uh;
		return t;
	endfunction

	// Offer one tick after a random gap and hold it until taken
	task automatic send_tick(input tick_t t);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < in_idle_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid           <= 1'b1;
		start_req          <= t.start;
		target_distance    <= t.tgt;
		target_angle       <= t.tang;
		left_position      <= t.lpos;
		right_raw_position <= t.rraw;
		yaw_angle          <= t.yaw;
		heading_angle      <= t.head;
		use_heading        <= t.use_h;
		do @(posedge clk); while (in_stall);
		sent_ticks++;
	endtask

	// Full-width noise on every field
	task automatic send_noise();
		send_tick(make_tick($urandom_range(0, 7) == 0, $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1))));
	endtask

	// One move: start request, then errors that decay toward the target with noise
	task automatic run_move();
		int n, amp, tgt, tang, el, er, et, yaw, head;
		logic uh;
		n   = $urandom_range(20, 130);
		amp = ($urandom_range(0, 3) == 0) ? 80 : 12;
		tgt = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 4000000)) - 2000000
			: int'($urandom_range(0, 2000)) - 1000;
		el = int'($urandom_range(0, 40000)) - 20000;
		er = int'($urandom_range(0, 40000)) - 20000;
		et = int'($urandom_range(0, 1600)) - 800;
		uh = 1'($urandom_range(0, 1));
		tang = uh ? int'($urandom_range(0, 5760)) : int'($urandom_range(0, 5760)) - 2880;
		for (int i = 0; i < n; i++) begin
			if (uh) begin
				head = clip_int(tang + et, 0, 5760);
				yaw  = int'($urandom_range(0, 5760)) - 2880;
			end else begin
				yaw  = clip_int(tang + et, -2880, 2880);
				head = $urandom_range(0, 5760);
			end
			send_tick(make_tick(i == 0, tgt, tang, tgt - el, er - tgt, yaw, head, uh));
			el = el - el / 4 + int'($urandom_range(0, 2 * amp)) - amp;
			er = er - er / 4 + int'($urandom_range(0, 2 * amp)) - amp;
			et = et - et / 4 + int'($urandom_range(0, 16)) - 8;
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_gains(input logic [15:0] kp, ki, kd, tkp, tki, tkd, maxp, tmo);
		write_reg(CFG_KP, kp);
		write_reg(CFG_KI, ki);
		write_reg(CFG_KD, kd);
		write_reg(CFG_TURN_KP, tkp);
		write_reg(CFG_TURN_KI, tki);
		write_reg(CFG_TURN_KD, tkd);
		write_reg(CFG_MAX_POWER, maxp);
		write_reg(CFG_TIMEOUT, tmo);
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic await_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stimulus
		int first;
		bit hold_done;
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		start_req          = 1'b0;
		target_distance    = '0;
		target_angle       = '0;
		left_position      = '0;
		right_raw_position = '0;
		yaw_angle          = '0;
		heading_angle      = '0;
		use_heading        = 1'b0;
		cfg_valid          = 1'b0;
		cfg_index          = CFG_KP;
		cfg_data           = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes and out-of-range angles under reset gains
		send_tick(make_tick(1'b1, 0, 0, 0, 0, 0, 0, 1'b0));
		send_tick(make_tick(1'b0, 8388607, 5760, -8388608, 8388607, 2880, 0, 1'b0));
		send_tick(make_tick(1'b0, -8388608, -5760, 8388607, -8388608, -2880, 5760, 1'b1));
		send_tick(make_tick(1'b0, 0, -8192, 0, 0, -4096, 8191, 1'b1));
		send_tick(make_tick(1'b0, 0, 8191, 0, 0, 4095, 0, 1'b0));
		// Settle: both errors on the band edge for twelve ticks
		for (int i = 0; i < 12; i++)
			send_tick(make_tick(i == 0, 1000, 0, 1032, -968, 0, 0, 1'b0));
		// One tick just out of band clears the run, then back in band
		send_tick(make_tick(1'b0, 1000, 0, 967, -968, 0, 0, 1'b0));
		send_tick(make_tick(1'b0, 1000, 0, 968, -1032, 0, 0, 1'b0));

		// Random phases, each under its own gains and idling mix
		for (int p = 0; p < NUM_PHASES; p++) begin
			await_drain();
			case (p)
				0: set_gains(16'd179, 16'd0, 16'd512, 16'd51, 16'd0, 16'd0, 16'd2560, 16'd1);
				1: set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'hFFFF, 16'h00FF);
				2: set_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
				NUM_PHASES - 1: set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()),
					16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
					16'($urandom()));
				default: set_gains(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 15)),
					16'($urandom_range(0, 4095)), 16'($urandom_range(0, 1023)),
					16'($urandom_range(0, 7)), 16'($urandom_range(0, 1023)),
					16'($urandom_range(0, 65535)),
					{8'($urandom_range(0, 255)), 8'($urandom_range(0, 2))});
			endcase
			case (p % 4)
				0: begin in_idle_pct = 0;  stall_pct = 0;  end
				1: begin in_idle_pct = 58; stall_pct = 0;  end
				2: begin in_idle_pct = 0;  stall_pct = 58; end
				default: begin in_idle_pct = 17; stall_pct = 17; end
			endcase
			first = sent_ticks;
			hold_done = 1'b0;
			while (sent_ticks - first < ITEMS_PER_PHASE) begin
				// Long output hold while requests keep coming
				if (p % 4 == 0 && !hold_done && sent_ticks - first >= 30) begin
					hold_trigger++;
					hold_done = 1'b1;
				end
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 5)) send_noise();
				end else begin
					run_move();
				end
			end
		end

		await_drain();
		$display("Run: %0d ticks over %0d gain sets (reset, all-zero, all-ones, random),",
			sent_ticks, NUM_PHASES + 1);
		$display("  %0d drive commands checked, %0d settled, %0d timed out",
			checked, settled_seen, timeout_seen);
		if (err_count == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/dspd_pkg.sv
design/dspd_pid_lane.sv
design/dual_side_pid_drive_with_heading.sv
tb/drive_cmd_checker.sv
tb/testbench.sv
